// ===== rtl/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Field widths of the transactions
  localparam int SIZE_W   = 16;
  localparam int BLKIDX_W = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 16'd64;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   request_size;
    logic                block_present;
    logic [BLKIDX_W-1:0] block_index;
  } fbfl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLKIDX_W-1:0] granted_block;
    logic [COUNT_W-1:0]  blocks_in_use;
    logic [COUNT_W-1:0]  peak_in_use;
  } fbfl_out_t;

endpackage

// ===== rtl/fbfl_ram.sv =====
// ----------------------------------------------------------------------------
// fbfl_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fixed_block_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool managed as a LIFO linked free list held in an
// on-chip next-pointer RAM.
// ----------------------------------------------------------------------------
// Usage: after reset the block chains the next-pointer RAM as 0,1,2,...;
// busy stays high for that chaining pass, and block_size writes are still
// taken. A transaction is accepted on a rising edge with start high and busy
// low. For frees and refused allocates the result appears in the cycle after
// acceptance and busy stays low. A granted allocate waits on the registered
// read of the next-pointer RAM: busy is high in S_READ while the head's link
// is fetched, and the result follows. Each result is presented for exactly
// one cycle with out_valid high; there is no back-pressure on the result
// side, so the receiver must capture it on that edge.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  fbfl_pkg::fbfl_in_t            in_data,
  // result channel
  output logic                          out_valid,
  output fbfl_pkg::fbfl_out_t           out_data,
  // configuration: block_size
  input  logic                          cfg_we,
  input  logic [fbfl_pkg::SIZE_W-1:0]   cfg_wdata
);

  import fbfl_pkg::*;

  typedef enum logic [1:0] {
    S_INIT,   // chaining pass over the RAM after reset
    S_IDLE,   // ready for a transaction
    S_READ    // allocate waiting for the head's next pointer
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic [SIZE_W-1:0] bsize_r;
  logic              out_valid_r, out_valid_nxt;
  fbfl_out_t         out_data_r, out_data_nxt;

  // RAM port signals
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr, mem_wdata, mem_rdata;

  logic [CNT_W-1:0]  cnt_inc;
  logic              clr_last;
  logic              free_valid;

  fbfl_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (IDX_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cnt_inc    = CNT_W'(cnt_r + 1'b1);
  assign clr_last   = (clr_cnt_r == IDX_W'(NUM_BLOCKS - 1));
  // a free naming no block, or one outside the pool, is ignored
  assign free_valid = in_data.block_present && (32'(in_data.block_index) < NUM_BLOCKS);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = head_r;
    mem_wdata     = head_r;
    mem_raddr     = head_r;

    unique case (state_r)
      S_INIT: begin
        // entry i links to i+1, last entry wraps to 0
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = clr_last ? '0 : IDX_W'(clr_cnt_r + 1'b1);
        clr_cnt_nxt = IDX_W'(clr_cnt_r + 1'b1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          out_data_nxt.granted_block = '0;
          out_data_nxt.blocks_in_use = COUNT_W'(cnt_r);
          out_data_nxt.peak_in_use   = COUNT_W'(peak_r);
          if (in_data.command == CMD_ALLOC) begin
            priority if (in_data.request_size > bsize_r) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_TOO_LARGE;
            end else if (cnt_r >= CNT_W'(NUM_BLOCKS)) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_EMPTY;
            end else begin
              // fetch the head's link; result goes out once it returns
              mem_re    = 1'b1;
              mem_raddr = head_r;
              state_nxt = S_READ;
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (free_valid) begin
              // LIFO push: freed block points at old head
              mem_we    = 1'b1;
              mem_waddr = IDX_W'(in_data.block_index);
              mem_wdata = head_r;
              head_nxt  = IDX_W'(in_data.block_index);
              cnt_nxt   = (cnt_r == '0) ? '0 : CNT_W'(cnt_r - 1'b1);
              out_data_nxt.status        = ST_DONE;
              out_data_nxt.blocks_in_use = COUNT_W'(cnt_nxt);
            end else begin
              out_data_nxt.status = ST_IGNORED;
            end
          end
        end
      end

      S_READ: begin
        head_nxt      = mem_rdata;
        cnt_nxt       = cnt_inc;
        peak_nxt      = (cnt_inc > peak_r) ? cnt_inc : peak_r;
        out_valid_nxt = 1'b1;
        out_data_nxt.status        = ST_DONE;
        out_data_nxt.granted_block = BLKIDX_W'(head_r);
        out_data_nxt.blocks_in_use = COUNT_W'(cnt_inc);
        out_data_nxt.peak_in_use   = COUNT_W'(peak_nxt);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      peak_r      <= '0;
      bsize_r     <= BLOCK_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bsize_r <= cfg_wdata;
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks

  // in-use count never exceeds the pool
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_BLOCKS))
    else $error("in-use count above pool size");

  // peak always covers the current count
  a_peak_ge_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r)
    else $error("peak below in-use count");

  // a granted allocate answers only after the head's link is fetched in S_READ
  a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_data.command == CMD_ALLOC &&
     in_data.request_size <= bsize_r && cnt_r < CNT_W'(NUM_BLOCKS))
    |=> !out_valid_r ##1 out_valid_r)
    else $error("allocate result not two cycles after acceptance");

  // every result stems from an accepted transaction or a finished fetch
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r == S_IDLE && start) || $past(state_r == S_READ)))
    else $error("result with no transaction behind it");

  // a free, taken or ignored, never raises the in-use count
  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_data.command == CMD_FREE)
    |=> cnt_r <= $past(cnt_r))
    else $error("free raised the in-use count");

endmodule
